// ----- sv/cpr_pkg.sv -----
// Shared types, constants and the pad-byte table of the crop/pad address generator.
package cpr_pkg;

    // Cursor and raster size width; wide enough for pad + kept + pad.
    localparam int unsigned CUR_W   = 14;
    // Width of the source coordinates on the result.
    localparam int unsigned SRC_W   = 13;
    // Widths of the configuration registers.
    localparam int unsigned OFS_W   = 12;
    localparam int unsigned KEPT_W  = 13;
    localparam int unsigned PLANE_W = 3;
    localparam int unsigned PIX_W   = 8;

    // Largest kept size; larger register values count as this.
    localparam logic [KEPT_W-1:0] DIM_MAX = 13'd4096;

    // Queue between the front and the back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // Register indexes of the configuration port.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEPT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEPT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_RIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_BOTTOM  = 3'd7;

    // Plane codes.
    localparam logic [PLANE_W-1:0] PLANE_LUMA  = 3'd0;
    localparam logic [PLANE_W-1:0] PLANE_CB    = 3'd1;
    localparam logic [PLANE_W-1:0] PLANE_CR    = 3'd2;
    localparam logic [PLANE_W-1:0] PLANE_ALPHA = 3'd3;

    localparam logic [PIX_W-1:0] PAD_LUMA   = 8'h00;
    localparam logic [PIX_W-1:0] PAD_CHROMA = 8'h80;
    localparam logic [PIX_W-1:0] PAD_ALPHA  = 8'hff;
    localparam logic [PIX_W-1:0] PAD_OTHER  = 8'h00;

    typedef struct packed {
        logic [OFS_W-1:0]  crop_left;
        logic [OFS_W-1:0]  crop_top;
        logic [KEPT_W-1:0] kept_width;
        logic [KEPT_W-1:0] kept_height;
        logic [OFS_W-1:0]  pad_left;
        logic [OFS_W-1:0]  pad_top;
        logic [OFS_W-1:0]  pad_right;
        logic [OFS_W-1:0]  pad_bottom;
    } t_cfg;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        logic               is_pad;
        logic [PLANE_W-1:0] plane;
        logic [CUR_W-1:0]   row;
        logic [CUR_W-1:0]   col;
        logic               last_in_line;
        logic               last_in_frame;
    } t_item;

    function automatic logic [PIX_W-1:0] pad_byte(input logic [PLANE_W-1:0] plane);
        logic [PIX_W-1:0] v;
        unique case (plane) inside
            PLANE_LUMA:         v = PAD_LUMA;
            PLANE_CB, PLANE_CR: v = PAD_CHROMA;
            PLANE_ALPHA:        v = PAD_ALPHA;
            default:            v = PAD_OTHER;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/crop_pad_raster_address_gen_top.sv -----
// Top level of the crop/pad raster address generator: registers and stream ports.
//
// Each input word asks for the next output pixel of one picture plane. The
// raster is pad_left + kept_width + pad_right pixels wide and pad_top +
// kept_height + pad_bottom lines high. For every word one result word comes
// out: either a pad pixel with the pad byte of the plane, or the source row
// and column an external memory must read. tlast marks the end of a line and
// tuser bit 1 the end of the frame; start_req sends the cursor to the origin.
//
// A word accepted on the request side goes into the queue and from there into
// the output register, whose contents are the result on the master side.
// One word is taken every cycle while the queue has room; the walker advances
// its cursor on each word, and a four-word queue plus the output register let
// the receiver stall without stopping the walker until the queue fills. The cycle
// after any register write the input is not taken, while the derived raster size settles.
// Reset clears all registers, the cursor, the queue and the output valid.
// Write registers only when no pixel is in flight; the block does not enforce it.
module crop_pad_raster_address_gen_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] start_req, rest zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] plane
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] pad_value, [20:8] src_row, [33:21] src_col
    output logic        m_axis_tlast,   // last_in_line
    output logic [1:0]  m_axis_tuser    // [0] is_pad, [1] last_in_frame
);

    cpr_pkg::t_cfg  r_cfg;
    cpr_pkg::t_item front_item, q_item;
    logic           push, pop, q_full, q_valid;
    logic           is_pad, lil, lif;
    logic [cpr_pkg::PIX_W-1:0] pad_value;
    logic [cpr_pkg::SRC_W-1:0] src_row, src_col;

    // Register file; every index of the port maps to a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cpr_pkg::REG_CROP_LEFT:   r_cfg.crop_left   <= i_cfg_data[11:0];
                cpr_pkg::REG_CROP_TOP:    r_cfg.crop_top    <= i_cfg_data[11:0];
                cpr_pkg::REG_KEPT_WIDTH:  r_cfg.kept_width  <= i_cfg_data;
                cpr_pkg::REG_KEPT_HEIGHT: r_cfg.kept_height <= i_cfg_data;
                cpr_pkg::REG_PAD_LEFT:    r_cfg.pad_left    <= i_cfg_data[11:0];
                cpr_pkg::REG_PAD_TOP:     r_cfg.pad_top     <= i_cfg_data[11:0];
                cpr_pkg::REG_PAD_RIGHT:   r_cfg.pad_right   <= i_cfg_data[11:0];
                cpr_pkg::REG_PAD_BOTTOM:  r_cfg.pad_bottom  <= i_cfg_data[11:0];
                default:                  r_cfg <= r_cfg;
            endcase
        end
    end

    cpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_we    (i_cfg_we),
        .i_valid     (s_axis_tvalid),
        .i_start_req (s_axis_tdata[0]),
        .i_plane     (s_axis_tuser),
        .i_q_full    (q_full),
        .o_ready     (s_axis_tready),
        .o_push      (push),
        .o_item      (front_item)
    );

    cpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cpr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_item          (q_item),
        .o_pop           (pop),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_is_pad        (is_pad),
        .o_pad_value     (pad_value),
        .o_src_row       (src_row),
        .o_src_col       (src_col),
        .o_last_in_line  (lil),
        .o_last_in_frame (lif)
    );

    assign m_axis_tdata = {6'd0, src_col, src_row, pad_value};
    assign m_axis_tlast = lil;
    assign m_axis_tuser = {lif, is_pad};

endmodule

// ----- sv/cpr_front.sv -----
// Raster walker: accepts words, advances the output cursor and classifies each pixel.
module cpr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpr_pkg::t_cfg        i_cfg,
    input  logic                 i_cfg_we,
    input  logic                 i_valid,
    input  logic                 i_start_req,
    input  logic [cpr_pkg::PLANE_W-1:0] i_plane,
    input  logic                 i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output cpr_pkg::t_item       o_item
);

    localparam int unsigned CW = cpr_pkg::CUR_W;

    // Raster geometry derived from the registers and registered behind them.
    logic [CW-1:0] r_w, r_h, r_w_m1, r_h_m1, r_col_end, r_row_end;
    logic          r_w_zero, r_h_zero;
    logic          r_settle;
    logic [CW-1:0] r_col, r_row;

    logic [cpr_pkg::KEPT_W-1:0] kw, kh;
    logic [CW-1:0] n_w, n_h;
    logic [CW-1:0] n_col, n_row;
    logic [CW-1:0] c0, r0, c1, r1, r2;
    logic          wrap_col, empty, pad, lil, lif, accept;

    assign kw  = (i_cfg.kept_width  > cpr_pkg::DIM_MAX) ? cpr_pkg::DIM_MAX : i_cfg.kept_width;
    assign kh  = (i_cfg.kept_height > cpr_pkg::DIM_MAX) ? cpr_pkg::DIM_MAX : i_cfg.kept_height;
    assign n_w = {2'b00, i_cfg.pad_left} + {1'b0, kw} + {2'b00, i_cfg.pad_right};
    assign n_h = {2'b00, i_cfg.pad_top}  + {1'b0, kh} + {2'b00, i_cfg.pad_bottom};

    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_h       <= n_h;
        r_w_m1    <= n_w - 14'd1;
        r_h_m1    <= n_h - 14'd1;
        r_w_zero  <= (n_w == '0);
        r_h_zero  <= (n_h == '0);
        r_col_end <= {2'b00, i_cfg.pad_left} + {1'b0, kw};
        r_row_end <= {2'b00, i_cfg.pad_top}  + {1'b0, kh};
    end

    // The geometry registers lag a write, so hold off input in the cycle after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 1'b1;
        end else begin
            r_settle <= i_cfg_we;
        end
    end

    assign o_ready = !i_q_full && !r_settle;
    assign accept  = i_valid && o_ready;

    always_comb begin
        empty    = r_w_zero || r_h_zero;
        c0       = i_start_req ? '0 : r_col;
        r0       = i_start_req ? '0 : r_row;
        wrap_col = (c0 >= r_w);
        c1       = wrap_col ? '0 : c0;
        r1       = wrap_col ? r0 + 14'd1 : r0;
        r2       = (r1 >= r_h) ? '0 : r1;
        pad      = (r2 < {2'b00, i_cfg.pad_top}) || (r2 >= r_row_end)
                || (c1 < {2'b00, i_cfg.pad_left}) || (c1 >= r_col_end);
        lil      = (c1 == r_w_m1);
        lif      = lil && (r2 == r_h_m1);

        o_item.plane = i_plane;
        if (empty) begin
            o_item.is_pad        = 1'b1;
            o_item.row           = '0;
            o_item.col           = '0;
            o_item.last_in_line  = 1'b1;
            o_item.last_in_frame = 1'b1;
            n_col                = '0;
            n_row                = '0;
        end else begin
            o_item.is_pad        = pad;
            o_item.row           = r2;
            o_item.col           = c1;
            o_item.last_in_line  = lil;
            o_item.last_in_frame = lif;
            if (lif) begin
                n_col = '0;
                n_row = '0;
            end else if (lil) begin
                n_col = '0;
                n_row = r2 + 14'd1;
            end else begin
                n_col = c1 + 14'd1;
                n_row = r2;
            end
        end
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

`ifndef SYNTH
    a_settle_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("input accepted while geometry was settling");
    a_frame_end_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_item.last_in_frame) |=> (r_col == '0 && r_row == '0))
        else $error("cursor not at origin after the last pixel of a frame");
`endif

endmodule

// ----- sv/cpr_queue.sv -----
// Short queue of classified pixels between the walker and the address stage.
module cpr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cpr_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output cpr_pkg::t_item o_item
);

    localparam int unsigned AW = cpr_pkg::Q_AW;

    cpr_pkg::t_item r_mem [cpr_pkg::Q_DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [AW:0]    r_count;

    assign o_full  = (r_count == AW'(0) + (AW+1)'(cpr_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");
`endif

endmodule

// ----- sv/cpr_back.sv -----
// Address stage: forms source coordinates and the pad byte into the output register.
module cpr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cpr_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  cpr_pkg::t_item i_item,
    output logic           o_pop,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic           o_is_pad,
    output logic [cpr_pkg::PIX_W-1:0] o_pad_value,
    output logic [cpr_pkg::SRC_W-1:0] o_src_row,
    output logic [cpr_pkg::SRC_W-1:0] o_src_col,
    output logic           o_last_in_line,
    output logic           o_last_in_frame
);

    localparam int unsigned CW = cpr_pkg::CUR_W;

    logic              r_valid;
    logic              load;
    logic [CW-1:0]     row_sum, col_sum;

    // Source coordinates wrap modulo 2^13, as the address bus does.
    assign row_sum = {2'b00, i_cfg.crop_top}  + i_item.row - {2'b00, i_cfg.pad_top};
    assign col_sum = {2'b00, i_cfg.crop_left} + i_item.col - {2'b00, i_cfg.pad_left};

    assign load  = i_q_valid && (!r_valid || i_out_ready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_is_pad        <= i_item.is_pad;
            o_pad_value     <= i_item.is_pad ? cpr_pkg::pad_byte(i_item.plane) : '0;
            o_src_row       <= i_item.is_pad ? '0 : row_sum[cpr_pkg::SRC_W-1:0];
            o_src_col       <= i_item.is_pad ? '0 : col_sum[cpr_pkg::SRC_W-1:0];
            o_last_in_line  <= i_item.last_in_line;
            o_last_in_frame <= i_item.last_in_frame;
        end
    end

    assign o_out_valid = r_valid;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the crop/pad raster address generator.
`timescale 1ns / 100ps

module tb;

    // A stretch this long without any word moving, while work is pending, ends the run.
    localparam int unsigned STALL_LIMIT  = 2000;
    // Length of the single long receiver hold-off that backs the block up.
    localparam int unsigned HOLD_CYCLES  = 60;
    // Request words in the random part of the run.
    localparam int unsigned RANDOM_WORDS = 525;
    // The last words of the random part run without any idling.
    localparam int unsigned TAIL_WORDS   = 100;
    // Local names for the package widths used in casts.
    localparam int unsigned PL_W  = cpr_pkg::PLANE_W;
    localparam int unsigned DAT_W = cpr_pkg::KEPT_W;
    localparam int unsigned IDX_W = cpr_pkg::CFG_IDX_W;

    // One request word: restart flag and plane index.
    typedef struct packed {
        logic                        start;
        logic [cpr_pkg::PLANE_W-1:0] plane;
    } t_req_word;

    // One result word as the block should describe the output pixel.
    typedef struct packed {
        logic                        is_pad;
        logic [cpr_pkg::PIX_W-1:0]   pad_value;
        logic [cpr_pkg::SRC_W-1:0]   src_row;
        logic [cpr_pkg::SRC_W-1:0]   src_col;
        logic                        eol;
        logic                        eof;
    } t_pixel;

    logic                          i_clk;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [cpr_pkg::CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [cpr_pkg::KEPT_W-1:0]    i_cfg_data    = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = '0;   // [0] start_req, rest zero
    logic [2:0]                    s_axis_tuser  = '0;   // [2:0] plane
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [39:0]                   m_axis_tdata;  // [7:0] pad_value, [20:8] src_row, [33:21] src_col
    logic                          m_axis_tlast;  // last_in_line
    logic [1:0]                    m_axis_tuser;  // [0] is_pad, [1] last_in_frame

    crop_pad_raster_address_gen_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Our own copy of the register file and of the raster cursor. The register
    // copy changes only while nothing is in flight, so the prediction made when
    // a request word is accepted always sees the same settings as the block.
    cpr_pkg::t_cfg             raster_cfg = '0;
    logic [cpr_pkg::CUR_W-1:0] cur_col    = '0;
    logic [cpr_pkg::CUR_W-1:0] cur_row    = '0;

    t_req_word req_backlog[$];   // request words not yet offered to the block
    t_pixel    pixels_due[$];    // predicted result words, oldest first

    // Knobs that the stimulus process sets with nonblocking writes.
    logic send_idle_en = 1'b0;
    logic recv_idle_en = 1'b0;
    logic hold_arm     = 1'b0;

    int unsigned mismatches = 0;
    int unsigned words_in   = 0;
    int unsigned words_out  = 0;
    int unsigned pad_words  = 0;
    int unsigned copy_words = 0;
    int unsigned line_ends  = 0;
    int unsigned frame_ends = 0;
    int unsigned settings   = 0;

    // Works out the next output pixel of the raster and advances the cursor.
    // The raster is pad_left + kept_width + pad_right wide and pad_top +
    // kept_height + pad_bottom high, kept sizes clamped to DIM_MAX.
    function automatic t_pixel walk_raster(input logic start,
                                           input logic [cpr_pkg::PLANE_W-1:0] plane);
        int unsigned               kw;
        int unsigned               kh;
        int unsigned               w;
        int unsigned               h;
        int unsigned               col;
        int unsigned               row;
        logic [31:0]               src_r;
        logic [31:0]               src_c;
        logic [cpr_pkg::PIX_W-1:0] fill;
        t_pixel                    px;
        kw = 32'((raster_cfg.kept_width > cpr_pkg::DIM_MAX) ? cpr_pkg::DIM_MAX
                                                            : raster_cfg.kept_width);
        kh = 32'((raster_cfg.kept_height > cpr_pkg::DIM_MAX) ? cpr_pkg::DIM_MAX
                                                             : raster_cfg.kept_height);
        w  = 32'(raster_cfg.pad_left) + kw + 32'(raster_cfg.pad_right);
        h  = 32'(raster_cfg.pad_top) + kh + 32'(raster_cfg.pad_bottom);
        case (plane) inside
            cpr_pkg::PLANE_LUMA:                  fill = cpr_pkg::PAD_LUMA;
            cpr_pkg::PLANE_CB, cpr_pkg::PLANE_CR: fill = cpr_pkg::PAD_CHROMA;
            cpr_pkg::PLANE_ALPHA:                 fill = cpr_pkg::PAD_ALPHA;
            default:                              fill = cpr_pkg::PAD_OTHER;
        endcase
        col = start ? 0 : 32'(cur_col);
        row = start ? 0 : 32'(cur_row);
        px  = '0;
        if (w == 0 || h == 0) begin
            // An empty raster: every word is a lone pad pixel closing line and frame.
            px.is_pad    = 1'b1;
            px.pad_value = fill;
            px.eol       = 1'b1;
            px.eof       = 1'b1;
            col          = 0;
            row          = 0;
        end else begin
            // A cursor left outside a shrunken raster wraps to the next line,
            // and past the last line to the top.
            if (col >= w) begin
                col = 0;
                row = row + 1;
            end
            if (row >= h) begin
                row = 0;
            end
            px.is_pad = row < 32'(raster_cfg.pad_top) ||
                        row >= 32'(raster_cfg.pad_top) + kh ||
                        col < 32'(raster_cfg.pad_left) ||
                        col >= 32'(raster_cfg.pad_left) + kw;
            px.eol    = (col == w - 1);
            px.eof    = px.eol && (row == h - 1);
            if (px.is_pad) begin
                px.pad_value = fill;
            end else begin
                src_r      = 32'(raster_cfg.crop_top) + row - 32'(raster_cfg.pad_top);
                src_c      = 32'(raster_cfg.crop_left) + col - 32'(raster_cfg.pad_left);
                px.src_row = src_r[cpr_pkg::SRC_W-1:0];
                px.src_col = src_c[cpr_pkg::SRC_W-1:0];
            end
            if (px.eof) begin
                col = 0;
                row = 0;
            end else if (px.eol) begin
                col = 0;
                row = row + 1;
            end else begin
                col = col + 1;
            end
        end
        cur_col = col[cpr_pkg::CUR_W-1:0];
        cur_row = row[cpr_pkg::CUR_W-1:0];
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] result word %0d: %s", $time, words_out, msg);
    endtask

    // Sender. A new word goes on the bus whenever the bus is free; before it,
    // a random gap may be inserted while idling is enabled.
    // The expected result is computed at the very edge where a word is taken.
    int unsigned send_gap = 0;
    t_req_word   next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pixels_due.push_back(walk_raster(s_axis_tdata[0], s_axis_tuser));
                words_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0 && send_idle_en) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_backlog.size() > 0 && send_idle_en &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 11);
                    s_axis_tvalid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    next_req = req_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, next_req.start};
                    s_axis_tuser  <= next_req.plane;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver and scoreboard. Every accepted result word is checked field by
    // field against the oldest prediction. Ready drops in random bursts, and
    // once, on request, for one long hold-off so the internal queue fills up
    // and the block has to push back on its request side.
    int unsigned recv_gap  = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    t_pixel      got;
    t_pixel      want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.is_pad    = m_axis_tuser[0];
                got.pad_value = m_axis_tdata[7:0];
                got.src_row   = m_axis_tdata[20:8];
                got.src_col   = m_axis_tdata[33:21];
                got.eol       = m_axis_tlast;
                got.eof       = m_axis_tuser[1];
                words_out++;
                if (got.is_pad === 1'b1) pad_words++;
                else copy_words++;
                if (got.eol === 1'b1) line_ends++;
                if (got.eof === 1'b1) frame_ends++;
                if (pixels_due.size() == 0) begin
                    report_mismatch("arrived with no prediction waiting");
                end else begin
                    want = pixels_due.pop_front();
                    if (got.is_pad !== want.is_pad)
                        report_mismatch($sformatf("is_pad %b, expected %b",
                                                  got.is_pad, want.is_pad));
                    if (got.pad_value !== want.pad_value)
                        report_mismatch($sformatf("pad_value 0x%h, expected 0x%h",
                                                  got.pad_value, want.pad_value));
                    if (got.src_row !== want.src_row)
                        report_mismatch($sformatf("src_row %0d, expected %0d",
                                                  got.src_row, want.src_row));
                    if (got.src_col !== want.src_col)
                        report_mismatch($sformatf("src_col %0d, expected %0d",
                                                  got.src_col, want.src_col));
                    if (got.eol !== want.eol)
                        report_mismatch($sformatf("last_in_line %b, expected %b",
                                                  got.eol, want.eol));
                    if (got.eof !== want.eof)
                        report_mismatch($sformatf("last_in_frame %b, expected %b",
                                                  got.eof, want.eof));
                end
            end
            if (hold_arm && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0 && recv_idle_en) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog. Counts cycles in which work is outstanding but no word moves on
    // either side; the longest legal stretch is the long hold-off, far below.
    int unsigned stalled_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (pixels_due.size() == 0 && req_backlog.size() == 0 && !s_axis_tvalid)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
        end
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("Timeout: %0d cycles without progress, %0d results outstanding",
                     stalled_cycles, pixels_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_word(input logic start, input logic [cpr_pkg::PLANE_W-1:0] plane);
        req_backlog.push_back('{start: start, plane: plane});
    endtask

    // Waits until every queued word is taken and every result has come back,
    // then lets the pipeline drain before registers move.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || s_axis_tvalid || pixels_due.size() != 0);
        repeat (4) @(posedge i_clk);
        settings++;
    endtask

    // One register write per clock; the enable stays high across a run of
    // writes and is dropped by close_writes afterwards.
    task automatic write_reg(input logic [cpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpr_pkg::KEPT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            cpr_pkg::REG_CROP_LEFT:   raster_cfg.crop_left   = val[cpr_pkg::OFS_W-1:0];
            cpr_pkg::REG_CROP_TOP:    raster_cfg.crop_top    = val[cpr_pkg::OFS_W-1:0];
            cpr_pkg::REG_KEPT_WIDTH:  raster_cfg.kept_width  = val;
            cpr_pkg::REG_KEPT_HEIGHT: raster_cfg.kept_height = val;
            cpr_pkg::REG_PAD_LEFT:    raster_cfg.pad_left    = val[cpr_pkg::OFS_W-1:0];
            cpr_pkg::REG_PAD_TOP:     raster_cfg.pad_top     = val[cpr_pkg::OFS_W-1:0];
            cpr_pkg::REG_PAD_RIGHT:   raster_cfg.pad_right   = val[cpr_pkg::OFS_W-1:0];
            default:                  raster_cfg.pad_bottom  = val[cpr_pkg::OFS_W-1:0];
        endcase
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stimulus. A directed opening walks the special cases, then random phases
    // each load a fresh raster geometry and stream a run of pixel requests.
    initial begin
        int unsigned                   words_queued;
        int unsigned                   phase_len;
        bit                            tail;
        bit                            pressure_done;
        logic [cpr_pkg::PLANE_W-1:0]   phase_plane;
        logic [cpr_pkg::CFG_IDX_W-1:0] idx;
        logic [cpr_pkg::KEPT_W-1:0]    val;

        words_queued  = 0;
        pressure_done = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        send_idle_en <= 1'b1;
        recv_idle_en <= 1'b1;

        // Registers at their reset value give an empty raster: every plane code
        // should come back as a single pad pixel ending both line and frame.
        for (int p = 0; p < 8; p++) begin
            queue_word(p[0], p[cpr_pkg::PLANE_W-1:0]);
        end
        wait_quiet();

        // Largest crop offsets with an oversized kept width (clamped to the
        // limit), so the copied pixels carry the biggest source coordinates.
        // Bit 12 written to a 12-bit register must be dropped.
        write_reg(cpr_pkg::REG_CROP_LEFT, 13'd4095);
        write_reg(cpr_pkg::REG_CROP_TOP, 13'd4095);
        write_reg(cpr_pkg::REG_KEPT_WIDTH, 13'h1fff);
        write_reg(cpr_pkg::REG_KEPT_HEIGHT, 13'd2);
        write_reg(cpr_pkg::REG_PAD_LEFT, 13'd1);
        write_reg(cpr_pkg::REG_PAD_TOP, 13'd0);
        write_reg(cpr_pkg::REG_PAD_RIGHT, 13'd0);
        write_reg(cpr_pkg::REG_PAD_BOTTOM, 13'h1fff);
        close_writes();
        queue_word(1'b1, cpr_pkg::PLANE_ALPHA);
        queue_word(1'b0, cpr_pkg::PLANE_CR);
        queue_word(1'b0, cpr_pkg::PLANE_CB);
        queue_word(1'b1, cpr_pkg::PLANE_LUMA);
        wait_quiet();

        // Widest pad borders around nothing: a raster made of padding only.
        write_reg(cpr_pkg::REG_KEPT_WIDTH, 13'd0);
        write_reg(cpr_pkg::REG_KEPT_HEIGHT, 13'd0);
        write_reg(cpr_pkg::REG_PAD_LEFT, 13'd4095);
        write_reg(cpr_pkg::REG_PAD_TOP, 13'd4095);
        write_reg(cpr_pkg::REG_PAD_RIGHT, 13'd4095);
        close_writes();
        queue_word(1'b0, 3'd7);
        queue_word(1'b0, 3'd4);
        wait_quiet();

        // A 4 x 3 raster with a one-pixel border on every side; stop two
        // pixels short of the frame end, at row 2, column 2.
        write_reg(cpr_pkg::REG_CROP_LEFT, 13'd7);
        write_reg(cpr_pkg::REG_CROP_TOP, 13'd9);
        write_reg(cpr_pkg::REG_KEPT_WIDTH, 13'd2);
        write_reg(cpr_pkg::REG_KEPT_HEIGHT, 13'd1);
        write_reg(cpr_pkg::REG_PAD_LEFT, 13'd1);
        write_reg(cpr_pkg::REG_PAD_TOP, 13'd1);
        write_reg(cpr_pkg::REG_PAD_RIGHT, 13'd1);
        write_reg(cpr_pkg::REG_PAD_BOTTOM, 13'd1);
        close_writes();
        queue_word(1'b1, cpr_pkg::PLANE_CB);
        for (int i = 0; i < 9; i++) begin
            queue_word(1'b0, cpr_pkg::PLANE_CB);
        end
        wait_quiet();

        // Shrink the raster to one column under the parked cursor: the column
        // wraps to the next line, which lies past the bottom, so it restarts
        // at the top.
        write_reg(cpr_pkg::REG_KEPT_WIDTH, 13'd1);
        write_reg(cpr_pkg::REG_PAD_LEFT, 13'd0);
        write_reg(cpr_pkg::REG_PAD_RIGHT, 13'd0);
        close_writes();
        for (int i = 0; i < 3; i++) begin
            queue_word(1'b0, cpr_pkg::PLANE_CR);
        end
        wait_quiet();

        // Random phases. Geometries are mostly small so frames close often;
        // now and then a register takes an extreme or oversized value. The
        // cursor is not reset between phases, so a new geometry often lands
        // on a cursor from the old one.
        while (words_queued < RANDOM_WORDS) begin
            phase_len = $urandom_range(15, 60);
            tail      = (words_queued + TAIL_WORDS >= RANDOM_WORDS);
            if (!pressure_done && words_queued >= RANDOM_WORDS / 2) begin
                // The sender streams back to back while the receiver holds off.
                pressure_done = 1'b1;
                phase_len     = 80;
                send_idle_en <= 1'b0;
                recv_idle_en <= 1'b0;
                hold_arm     <= 1'b1;
            end else begin
                send_idle_en <= !tail && ($urandom_range(0, 3) != 0);
                recv_idle_en <= !tail && ($urandom_range(0, 3) != 0);
            end
            for (int r = 0; r < 8; r++) begin
                if ($urandom_range(0, 3) == 0) continue;
                idx = IDX_W'(r);
                case (idx) inside
                    cpr_pkg::REG_CROP_LEFT, cpr_pkg::REG_CROP_TOP: begin
                        case ($urandom_range(0, 5))
                            0:       val = 13'd0;
                            1:       val = 13'd4095;
                            default: val = DAT_W'($urandom_range(0, 8191));
                        endcase
                    end
                    cpr_pkg::REG_KEPT_WIDTH, cpr_pkg::REG_KEPT_HEIGHT: begin
                        case ($urandom_range(0, 19))
                            0:       val = 13'd4096;
                            1:       val = 13'd4097;
                            2:       val = 13'h1fff;
                            3:       val = DAT_W'($urandom_range(0, 8191));
                            default: val = DAT_W'($urandom_range(0, 5));
                        endcase
                    end
                    default: begin
                        case ($urandom_range(0, 19))
                            0:       val = 13'd4095;
                            1:       val = DAT_W'($urandom_range(0, 8191));
                            default: val = DAT_W'($urandom_range(0, 2));
                        endcase
                        // Noise in bit 12, which a 12-bit register ignores.
                        if ($urandom_range(0, 3) == 0) val[cpr_pkg::KEPT_W-1] = 1'b1;
                    end
                endcase
                write_reg(idx, val);
            end
            close_writes();
            // A phase mostly serves one plane, as a real frame would.
            phase_plane = PL_W'($urandom_range(0, 7));
            for (int i = 0; i < phase_len; i++) begin
                queue_word($urandom_range(0, 19) == 0,
                           ($urandom_range(0, 7) == 0) ? PL_W'($urandom_range(0, 7))
                                                       : phase_plane);
            end
            words_queued += phase_len;
            wait_quiet();
        end

        repeat (20) @(posedge i_clk);
        $display("Streamed %0d request words through %0d raster settings, %0d results back.",
                 words_in, settings, words_out);
        $display("Results held %0d pad and %0d copied pixels, %0d line ends, %0d frame ends.",
                 pad_words, copy_words, line_ends, frame_ends);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
